// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BPS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bitplane serializer assertion failed");

// Check a property on every rising edge, reset included.
`define BPS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bitplane serializer assertion failed");

`endif

// ----- rtl/bps_pkg.sv -----
package bps_pkg;

  localparam int PlaneCount   = 6;
  localparam int MaxPlanes    = 6;
  localparam int WordWidth    = 16;
  localparam int ShiftWidth   = 32;
  localparam int ColorWidth   = 6;
  localparam int CountWidth   = 5;
  localparam int MaxPixels    = 32;
  localparam int PixCntWidth  = $clog2(MaxPixels + 1);
  localparam int ScrollWidth  = 4;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 4;
  localparam int HiresMax     = 14;
  localparam int LoresBase    = 15;

  typedef enum logic [1:0] {
    ReqCommit    = 2'd0,
    ReqSerialize = 2'd1,
    ReqEol       = 2'd2
  } req_type_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgHires     = 3'd0,
    CfgOddLores  = 3'd1,
    CfgEvenLores = 3'd2,
    CfgOddHires  = 3'd3,
    CfgEvenHires = 3'd4
  } cfg_idx_t;

  typedef logic [WordWidth-1:0] word_t;
  typedef word_t [MaxPlanes-1:0] plane_words_t;

  typedef struct packed {
    logic [ScrollWidth-1:0] odd;
    logic [ScrollWidth-1:0] even;
  } shift_amt_t;

  typedef struct packed {
    logic commit;
    logic clear;
    logic shift;
  } bank_ctl_t;

endpackage

// ----- rtl/bps_if.sv -----
interface bps_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic [bps_pkg::WordWidth-1:0]  plane1_word;
  logic [bps_pkg::WordWidth-1:0]  plane2_word;
  logic [bps_pkg::WordWidth-1:0]  plane3_word;
  logic [bps_pkg::WordWidth-1:0]  plane4_word;
  logic [bps_pkg::WordWidth-1:0]  plane5_word;
  logic [bps_pkg::WordWidth-1:0]  plane6_word;
  logic [bps_pkg::CountWidth-1:0] cylinder_count;

  modport source (
    output valid, req_type, plane1_word, plane2_word, plane3_word,
           plane4_word, plane5_word, plane6_word, cylinder_count,
    input  ready
  );
  modport sink (
    input  valid, req_type, plane1_word, plane2_word, plane3_word,
           plane4_word, plane5_word, plane6_word, cylinder_count,
    output ready
  );
endinterface

interface bps_pix_if;
  logic                           valid;
  logic                           ready;
  logic [bps_pkg::ColorWidth-1:0] pixel_color;
  logic                           last_pixel;

  modport source (output valid, pixel_color, last_pixel, input ready);
  modport sink (input valid, pixel_color, last_pixel, output ready);
endinterface

interface bps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bps_pkg::CfgIdxWidth-1:0]  index;
  logic [bps_pkg::CfgDataWidth-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/bitplane_pixel_serializer_core.sv -----
// Channel  Role    Payload
// req      sink    req_type, plane1_word..plane6_word, cylinder_count
// pix      source  pixel_color, last_pixel
// cfg      sink    index, data (always ready)
//
// Commit, end-of-line and unused requests finish on acceptance; req.ready stays high.
// Serialize emits N pixels, N = cylinder_count,
// doubled in hires, at most 32: the plane shifters move one place a pixel.
// A stalled pix channel holds the shifter; req.ready stays low until the last
// pixel is latched into the output register, which may still be waiting on pix.
// rst is synchronous and clears planes, configuration and sequencer.
module bitplane_pixel_serializer_core (
  input  logic      clk,
  input  logic      rst,
  bps_req_if.sink   req,
  bps_pix_if.source pix,
  bps_cfg_if.sink   cfg
);

  logic                           hires;
  bps_pkg::shift_amt_t            amt;
  bps_pkg::bank_ctl_t             ctl;
  bps_pkg::plane_words_t          words;
  logic [bps_pkg::PlaneCount-1:0] top_bits;

  assign words[0] = req.plane1_word;
  assign words[1] = req.plane2_word;
  assign words[2] = req.plane3_word;
  assign words[3] = req.plane4_word;
  assign words[4] = req.plane5_word;
  assign words[5] = req.plane6_word;

  bps_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .hires (hires),
    .amt   (amt)
  );

  bps_plane_bank u_bank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .amt      (amt),
    .words    (words),
    .top_bits (top_bits)
  );

  bps_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .pix      (pix),
    .hires    (hires),
    .top_bits (top_bits),
    .ctl      (ctl)
  );

endmodule

// ----- rtl/bps_cfg_regs.sv -----
module bps_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  bps_cfg_if.sink             cfg,
  output logic                hires,
  output bps_pkg::shift_amt_t amt
);

  logic                            hires_mode;
  logic [bps_pkg::ScrollWidth-1:0] odd_lores;
  logic [bps_pkg::ScrollWidth-1:0] even_lores;
  logic [bps_pkg::ScrollWidth-1:0] odd_hires;
  logic [bps_pkg::ScrollWidth-1:0] even_hires;
  logic [bps_pkg::ScrollWidth-1:0] odd_hires_sat;
  logic [bps_pkg::ScrollWidth-1:0] even_hires_sat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hires_mode <= 1'b0;
      odd_lores  <= '0;
      even_lores <= '0;
      odd_hires  <= '0;
      even_hires <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        bps_pkg::CfgHires:     hires_mode <= cfg.data[0];
        bps_pkg::CfgOddLores:  odd_lores  <= cfg.data;
        bps_pkg::CfgEvenLores: even_lores <= cfg.data;
        bps_pkg::CfgOddHires:  odd_hires  <= cfg.data;
        bps_pkg::CfgEvenHires: even_hires <= cfg.data;
        default: ;
      endcase
    end
  end

  // saturate hires delays
  always_comb begin
    odd_hires_sat  = (odd_hires > bps_pkg::ScrollWidth'(bps_pkg::HiresMax)) ?
                     bps_pkg::ScrollWidth'(bps_pkg::HiresMax) : odd_hires;
    even_hires_sat = (even_hires > bps_pkg::ScrollWidth'(bps_pkg::HiresMax)) ?
                     bps_pkg::ScrollWidth'(bps_pkg::HiresMax) : even_hires;
    if (hires_mode) begin
      amt.odd  = bps_pkg::ScrollWidth'(bps_pkg::HiresMax) - odd_hires_sat;
      amt.even = bps_pkg::ScrollWidth'(bps_pkg::HiresMax) - even_hires_sat;
    end else begin
      amt.odd  = bps_pkg::ScrollWidth'(bps_pkg::LoresBase) - odd_lores;
      amt.even = bps_pkg::ScrollWidth'(bps_pkg::LoresBase) - even_lores;
    end
  end

  assign hires = hires_mode;

endmodule

// ----- rtl/bps_plane_bank.sv -----
module bps_plane_bank (
  input  logic                            clk,
  input  logic                            rst,
  input  bps_pkg::bank_ctl_t              ctl,
  input  bps_pkg::shift_amt_t             amt,
  input  bps_pkg::plane_words_t           words,
  output logic [bps_pkg::PlaneCount-1:0]  top_bits
);

  logic [bps_pkg::ShiftWidth-1:0] shifter [bps_pkg::PlaneCount];
  logic [bps_pkg::ShiftWidth-1:0] merged  [bps_pkg::PlaneCount];

  always_comb begin
    logic [bps_pkg::ScrollWidth-1:0] s;
    logic [bps_pkg::ShiftWidth-1:0]  mask;
    for (int i = 0; i < bps_pkg::PlaneCount; i++) begin
      s    = i[0] ? amt.even : amt.odd;
      mask = bps_pkg::ShiftWidth'({bps_pkg::WordWidth{1'b1}}) << s;
      merged[i] = (shifter[i] & ~mask) |
                  ((bps_pkg::ShiftWidth'(words[i]) << s) & mask);
      top_bits[i] = shifter[i][bps_pkg::ShiftWidth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < bps_pkg::PlaneCount; i++) shifter[i] <= '0;
    end else if (ctl.commit) begin
      for (int i = 0; i < bps_pkg::PlaneCount; i++) shifter[i] <= merged[i];
    end else if (ctl.shift) begin
      for (int i = 0; i < bps_pkg::PlaneCount; i++) begin
        shifter[i] <= {shifter[i][bps_pkg::ShiftWidth-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/bps_seq.sv -----
module bps_seq (
  input  logic                           clk,
  input  logic                           rst,
  bps_req_if.sink                        req,
  bps_pix_if.source                      pix,
  input  logic                           hires,
  input  logic [bps_pkg::PlaneCount-1:0] top_bits,
  output bps_pkg::bank_ctl_t             ctl
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_t;

  state_t                           state;
  logic [bps_pkg::PixCntWidth-1:0]  remain;
  logic [bps_pkg::PixCntWidth-1:0]  cyl_px;
  logic [bps_pkg::PixCntWidth-1:0]  pixels;
  logic                             out_valid;
  logic [bps_pkg::ColorWidth-1:0]   color;
  logic                             last;
  logic                             accept;
  logic                             out_free;
  logic                             emit;

  assign req.ready = (state == StIdle);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || pix.ready;
  assign emit      = (state == StRun) && out_free;

  always_comb begin
    cyl_px = hires ? {req.cylinder_count, 1'b0}
                   : bps_pkg::PixCntWidth'(req.cylinder_count);
    pixels = (cyl_px > bps_pkg::PixCntWidth'(bps_pkg::MaxPixels)) ?
             bps_pkg::PixCntWidth'(bps_pkg::MaxPixels) : cyl_px;
  end

  assign ctl.commit = accept && (req.req_type == bps_pkg::ReqCommit);
  assign ctl.clear  = accept && (req.req_type == bps_pkg::ReqEol);
  assign ctl.shift  = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        StIdle: begin
          if (accept && (req.req_type == bps_pkg::ReqSerialize) && (pixels != '0)) begin
            state  <= StRun;
            remain <= pixels;
          end
        end
        StRun: begin
          if (emit) begin
            remain <= remain - 1'b1;
            if (remain == bps_pkg::PixCntWidth'(1)) state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
      if (emit) out_valid <= 1'b1;
      else if (pix.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      color <= bps_pkg::ColorWidth'(top_bits);
      last  <= (remain == bps_pkg::PixCntWidth'(1));
    end
  end

  assign pix.valid       = out_valid;
  assign pix.pixel_color = color;
  assign pix.last_pixel  = last;

endmodule

// ----- rtl/bps_checker.sv -----
`include "assert_macros.svh"

module bps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic [1:0]                      req_type,
  input logic [bps_pkg::CountWidth-1:0]  cylinder_count,
  input logic                            pix_valid,
  input logic                            pix_ready,
  input logic [bps_pkg::ColorWidth-1:0]  pixel_color,
  input logic                            last_pixel
);

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  `BPS_ASSERT(a_pix_hold, clk, rst, pix_valid && !pix_ready |=> pix_valid && $stable(pixel_color) && $stable(last_pixel))
  `BPS_ASSERT(a_busy_after_serialize, clk, rst, req_acc && (req_type == bps_pkg::ReqSerialize) && (cylinder_count != '0) |=> !req_ready)
  `BPS_ASSERT(a_single_cycle_other, clk, rst, req_acc && (req_type != bps_pkg::ReqSerialize) |=> req_ready)
  `BPS_ASSERT_ALWAYS(a_reset_quiet, clk, $past(rst) |-> !pix_valid && req_ready)

endmodule

bind bitplane_pixel_serializer_core bps_checker u_bps_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_type       (req.req_type),
  .cylinder_count (req.cylinder_count),
  .pix_valid      (pix.valid),
  .pix_ready      (pix.ready),
  .pixel_color    (pix.pixel_color),
  .last_pixel     (pix.last_pixel)
);
